// ===== sv/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants of the stepper ramp step generator.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int POS_W    = 16;              // position width
    localparam int SPD_FRAC = 16;              // speed fraction bits
    localparam int SPD_W    = 8 + SPD_FRAC;    // unsigned Q8.F speed
    localparam int PER_W    = 16;              // period register width
    localparam int DIVD_W   = 14 + SPD_FRAC;   // 10000 < 2^14

    localparam logic [DIVD_W-1:0] SCALED_TEN_K = DIVD_W'(10000) << SPD_FRAC;
    localparam logic [SPD_W-1:0]  SPD_MAX      = {SPD_W{1'b1}};
    localparam logic [PER_W-1:0]  PER_MAX      = {PER_W{1'b1}};
    localparam logic [15:0]       HOLD_MAX     = 16'hFFFF;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP   = 3'd4;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_PRESET = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [POS_W-1:0] target_position;
        logic [POS_W-1:0] preset_position;
    } t_in_item;

    typedef struct packed {
        logic [PER_W-1:0] period;
        logic             period_write;
        logic             step_pulse;
        logic             direction;
        logic [POS_W-1:0] position;
        logic             at_target;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSLOW,
        S_DFAST,
        S_TARGET,
        S_RAMP,
        S_PSTART,
        S_DPER,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        DSEL_SLOW,
        DSEL_FAST,
        DSEL_SPEED
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_slow;
        logic     cap_fast;
        logic     new_target;
        logic     ramp;
        logic     cap_period;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic ramp_tick;
        logic div_done;
        logic period_write;
    } t_status;

    // accel_step is in 1/65536 units; rescale to 2^-SPD_FRAC units
    function automatic logic [SPD_W-1:0] accel_scale(input logic [15:0] step);
        logic [SPD_W+15:0] wide;
        wide = {{SPD_W{1'b0}}, step};
        if (SPD_FRAC >= 16) begin
            wide = wide << (SPD_FRAC - 16);
        end else begin
            wide = wide >> (16 - SPD_FRAC);
        end
        return wide[SPD_W-1:0];
    endfunction

endpackage

// ===== sv/stepper_ramp_step_generator_top.sv =====
// ----------------------------------------------------------------------------
// stepper_ramp_step_generator_top
// Trapezoidal speed ramp and step pin generator for one stepper axis.
// ----------------------------------------------------------------------------
// Each input beat is a timer tick or a position preset and yields one result
// beat. A tick with the ramp enabled runs up to three divisions on a shared
// restoring divider (slow limit, fast limit, then period from speed); a tick
// with no motion pending skips the period division. Presets and ticks with the
// ramp off skip the divisions and go straight to loading their result. One
// beat is worked at a time; the result sits in an output register, so the
// next beat is accepted while the previous result waits. Configuration writes
// take effect on the clock edge; the user must make them only while idle,
// which the block itself does not enforce.
module stepper_ramp_step_generator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  stp_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output stp_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [stp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stp_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import stp_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    stp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    stp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/stp_div.sv =====
// ----------------------------------------------------------------------------
// stp_div
// Restoring divider: SCALED_TEN_K / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [stp_pkg::SPD_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [stp_pkg::DIVD_W-1:0] o_quotient
);
    import stp_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [SPD_W-1:0]  r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [SPD_W-1:0]  r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [SPD_W:0] w_trial;
    logic [SPD_W:0] w_sub;
    logic           w_ge;

    // a zero divisor yields an all-ones quotient, which callers saturate
    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_sub   = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= SCALED_TEN_K;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[SPD_W-1:0] : w_trial[SPD_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/stp_dp.sv =====
// ----------------------------------------------------------------------------
// stp_dp
// Datapath: config registers, axis state, ramp arithmetic, divider, result.
// ----------------------------------------------------------------------------
module stp_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  stp_pkg::t_in_item             i_in_data,
    input  logic                          i_cfg_we,
    input  logic [stp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stp_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  stp_pkg::t_cmd                 i_cmd,
    output stp_pkg::t_status              o_status,
    output stp_pkg::t_out_item            o_out_data
);
    import stp_pkg::*;

    // configuration
    logic             r_ramp_en;
    logic [PER_W-1:0] r_fixed_per;
    logic [PER_W-1:0] r_slow_per;
    logic [PER_W-1:0] r_fast_per;
    logic [15:0]      r_accel_step;

    // axis state
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_rec_tgt;
    logic [POS_W-1:0] r_prev_tgt;
    logic [POS_W-1:0] r_mid;
    logic [SPD_W-1:0] r_speed;
    logic [15:0]      r_hold;
    logic             r_pin;
    logic             r_dir;

    // current beat and working values
    logic             r_mode;
    logic [POS_W-1:0] r_tgt;
    logic [POS_W-1:0] r_pre;
    logic [SPD_W-1:0] r_slow_lim;
    logic [SPD_W-1:0] r_fast_lim;
    logic [PER_W-1:0] r_per;
    logic             r_wr;
    logic             r_accel_ph;
    t_out_item        r_out;

    // divider
    logic [SPD_W-1:0]  w_divisor;
    logic              w_div_busy;
    logic              w_div_done;
    logic [DIVD_W-1:0] w_quo;
    logic [SPD_W-1:0]  w_quo_spd;
    logic [PER_W-1:0]  w_quo_per;
    logic [PER_W-1:0]  w_per_capped;

    always_comb begin
        case (i_cmd.div_sel)
            DSEL_SLOW:  w_divisor = SPD_W'(r_slow_per);
            DSEL_FAST:  w_divisor = SPD_W'(r_fast_per);
            DSEL_SPEED: w_divisor = r_speed;
            default:    w_divisor = r_speed;
        endcase
    end

    stp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_quo_spd = (w_quo > DIVD_W'(SPD_MAX)) ? SPD_MAX : w_quo[SPD_W-1:0];
    assign w_quo_per = (w_quo > DIVD_W'(PER_MAX)) ? PER_MAX : w_quo[PER_W-1:0];
    assign w_per_capped = (r_accel_ph && (w_quo_per > r_fixed_per)) ? r_fixed_per
                                                                     : w_quo_per;

    // midpoint: recorded + (target - recorded) / 2, rounded toward zero
    logic signed [POS_W:0] w_diff;
    logic signed [POS_W:0] w_round;
    logic signed [POS_W:0] w_half;
    logic        [POS_W:0] w_mid_sum;

    assign w_diff    = $signed({1'b0, r_tgt}) - $signed({1'b0, r_rec_tgt});
    assign w_round   = w_diff + $signed({{POS_W{1'b0}}, w_diff[POS_W]});
    assign w_half    = w_round >>> 1;
    assign w_mid_sum = {1'b0, r_rec_tgt} + w_half;

    // ramp step
    logic             w_up;
    logic             w_down;
    logic             w_accel;
    logic [SPD_W-1:0] w_astep;
    logic [SPD_W:0]   w_sum;
    logic             w_clamp;
    logic [SPD_W-1:0] w_dec;

    assign w_up    = (r_prev_tgt < r_tgt);
    assign w_down  = (r_prev_tgt > r_tgt);
    assign w_accel = w_up ? (r_pos < r_mid) : (r_pos > r_mid);
    assign w_astep = accel_scale(r_accel_step);
    assign w_sum   = {1'b0, r_speed} + {1'b0, w_astep};
    assign w_clamp = w_sum[SPD_W] || (w_sum[SPD_W-1:0] > r_fast_lim);
    assign w_dec   = (r_speed >= w_astep) ? (r_speed - w_astep) : '0;

    // step pin logic of the finishing beat
    logic             n_pin;
    logic             n_dir;
    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] n_rec_tgt;
    logic             n_done;

    always_comb begin
        n_pin     = r_pin;
        n_dir     = r_dir;
        n_pos     = r_pos;
        n_rec_tgt = r_rec_tgt;
        n_done    = 1'b0;
        if (r_mode == MODE_PRESET) begin
            n_pos     = r_pre;
            n_rec_tgt = r_pre;
            n_done    = !r_pin && (r_pre == r_tgt);
        end else if (r_pin) begin
            n_pin = 1'b0;
        end else if (r_pos < r_tgt) begin
            n_dir = 1'b0;
            n_pos = r_pos + POS_W'(1);
            n_pin = 1'b1;
        end else if (r_pos > r_tgt) begin
            n_dir = 1'b1;
            n_pos = r_pos - POS_W'(1);
            n_pin = 1'b1;
        end else begin
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_en    <= 1'b1;
            r_fixed_per  <= PER_W'(499);
            r_slow_per   <= PER_W'(1299);
            r_fast_per   <= PER_W'(48);
            r_accel_step <= 16'd6554;
            r_pos        <= '0;
            r_rec_tgt    <= '0;
            r_prev_tgt   <= '0;
            r_mid        <= '0;
            r_speed      <= '0;
            r_hold       <= '0;
            r_pin        <= 1'b0;
            r_dir        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RAMP_ENABLE:  r_ramp_en    <= i_cfg_data[0];
                    CFG_FIXED_PERIOD: r_fixed_per  <= i_cfg_data;
                    CFG_SLOW_PERIOD:  r_slow_per   <= i_cfg_data;
                    CFG_FAST_PERIOD:  r_fast_per   <= i_cfg_data;
                    CFG_ACCEL_STEP:   r_accel_step <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.new_target && (r_tgt != r_rec_tgt)) begin
                r_mid      <= w_mid_sum[POS_W-1:0];
                r_prev_tgt <= r_rec_tgt;
                r_rec_tgt  <= r_tgt;
                r_speed    <= r_slow_lim;
                r_hold     <= '0;
            end
            if (i_cmd.ramp && (w_up || w_down)) begin
                if (w_accel) begin
                    if (w_clamp) begin
                        r_speed <= r_fast_lim;
                        if (r_hold < HOLD_MAX) begin
                            r_hold <= r_hold + 16'd1;
                        end
                    end else begin
                        r_speed <= w_sum[SPD_W-1:0];
                    end
                end else if (r_hold != '0) begin
                    r_hold <= r_hold - 16'd1;
                end else begin
                    r_speed <= (w_dec < r_slow_lim) ? r_slow_lim : w_dec;
                end
            end
            if (i_cmd.finish) begin
                r_pin     <= n_pin;
                r_dir     <= n_dir;
                r_pos     <= n_pos;
                r_rec_tgt <= n_rec_tgt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_in_data.mode;
            r_tgt      <= i_in_data.target_position;
            r_pre      <= i_in_data.preset_position;
            r_accel_ph <= 1'b0;
            if (i_in_data.mode == MODE_TICK && !r_ramp_en) begin
                r_per <= r_fixed_per;
                r_wr  <= 1'b1;
            end else begin
                r_per <= '0;
                r_wr  <= 1'b0;
            end
        end
        if (i_cmd.cap_slow) begin
            r_slow_lim <= w_quo_spd;
        end
        if (i_cmd.cap_fast) begin
            r_fast_lim <= w_quo_spd;
        end
        if (i_cmd.ramp && (w_up || w_down)) begin
            r_wr       <= 1'b1;
            r_accel_ph <= w_accel;
        end
        if (i_cmd.cap_period) begin
            r_per <= w_per_capped;
        end
        if (i_cmd.finish) begin
            r_out.period       <= r_per;
            r_out.period_write <= r_wr;
            r_out.step_pulse   <= n_pin;
            r_out.direction    <= n_dir;
            r_out.position     <= n_pos;
            r_out.at_target    <= n_done;
        end
    end

    assign o_status.ramp_tick    = (i_in_data.mode == MODE_TICK) && r_ramp_en;
    assign o_status.div_done     = w_div_done;
    assign o_status.period_write = (r_prev_tgt != r_tgt);
    assign o_out_data            = r_out;

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

    a_step_raises_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_mode == MODE_TICK && !r_pin && (r_pos != r_tgt)) |=>
        (r_pin && r_out.step_pulse))
        else $error("step pin not raised on a move");

    a_hold_only_in_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.ramp && !i_cmd.new_target) |=> $stable(r_hold))
        else $error("hold count changed outside the ramp update");
`endif

endmodule

// ===== sv/stp_ctrl.sv =====
// ----------------------------------------------------------------------------
// stp_ctrl
// Sequencer: walks one beat through limit divisions, ramp update and period.
// ----------------------------------------------------------------------------
module stp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  stp_pkg::t_status i_status,
    output stp_pkg::t_cmd    o_cmd
);
    import stp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_status.ramp_tick ? S_DSLOW : S_FINISH;
                end
            end
            S_DSLOW: begin
                if (i_status.div_done) begin
                    n_state = S_DFAST;
                end
            end
            S_DFAST: begin
                if (i_status.div_done) begin
                    n_state = S_TARGET;
                end
            end
            S_TARGET: n_state = S_RAMP;
            S_RAMP:   n_state = i_status.period_write ? S_PSTART : S_FINISH;
            S_PSTART: n_state = S_DPER;
            S_DPER: begin
                if (i_status.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DSEL_SLOW;
        case (r_state)
            S_IDLE: begin
                o_cmd.load      = w_accept;
                o_cmd.div_start = w_accept && i_status.ramp_tick;
            end
            S_DSLOW: begin
                o_cmd.cap_slow  = i_status.div_done;
                o_cmd.div_start = i_status.div_done;
                o_cmd.div_sel   = DSEL_FAST;
            end
            S_DFAST: begin
                o_cmd.cap_fast = i_status.div_done;
            end
            S_TARGET: o_cmd.new_target = 1'b1;
            S_RAMP:   o_cmd.ramp = 1'b1;
            S_PSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_SPEED;
            end
            S_DPER:   o_cmd.cap_period = i_status.div_done;
            S_FINISH: o_cmd.finish = w_out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_DSLOW || r_state == S_DFAST ||
                               r_state == S_DPER))
        else $error("divider finished outside a division state");

    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished beat did not reach the output");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted beat left the sequencer idle");
`endif

endmodule

// ===== tb/tb_stepper_ramp_step_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stepper_ramp_step_generator_top
// Self-checking bench for the stepper ramp step generator.
// ----------------------------------------------------------------------------
// Ticks and presets go in from a queue through a driver with random gaps. A
// bit-accurate axis model in the bench predicts each result beat at accept
// time, and a monitor with random stalls checks every field in order. The run
// steps through several register settings: defaults, ramp off, long holds at
// the fast limit, speed overflow, speed underflow, zero period registers and
// random settings. Registers change only with the block idle.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_step_generator_top;
    import stp_pkg::*;

    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam bit [63:0]  TEN_K       = 64'(SCALED_TEN_K);
    localparam bit [63:0]  SPEED_TOP   = 64'(SPD_MAX);

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             in_data = '0;
    logic                 o_out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    stepper_ramp_step_generator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Axis model: register copies and state
    // ------------------------------------------------------------------------
    bit              r_ramp  = 1'b1;
    bit [15:0]       r_fixed = 16'd499;
    bit [15:0]       r_slow  = 16'd1299;
    bit [15:0]       r_fast  = 16'd48;
    bit [15:0]       r_accel = 16'd6554;

    bit [POS_W-1:0]  axis_pos;
    bit [POS_W-1:0]  rec_tgt;
    bit [POS_W-1:0]  prev_tgt;
    longint          mid_pos;
    bit [SPD_W-1:0]  speed;
    bit [15:0]       held_ticks;
    bit              pin_up;
    bit              dir_down;

    t_in_item        cmd_q[$];
    t_out_item       axis_results_q[$];
    int              cmds_sent;
    int              results_seen;
    int              mismatches;
    int              plan_pos;
    int              idle_pct = 20;
    int              gap_left;
    int              stall_left;
    int              cycles;

    function automatic bit [63:0] speed_limit(input bit [15:0] per);
        bit [63:0] q;
        if (per == 16'd0) return SPEED_TOP;
        q = TEN_K / per;
        if (q > SPEED_TOP) return SPEED_TOP;
        return q;
    endfunction

    function automatic bit [15:0] period_of(input bit [63:0] spd);
        bit [63:0] q;
        if (spd == 64'd0) return PER_MAX;
        q = TEN_K / spd;
        if (q > 64'(PER_MAX)) return PER_MAX;
        return q[15:0];
    endfunction

    function automatic bit [63:0] accel_units();
        if (SPD_FRAC >= 16) return 64'(r_accel) << (SPD_FRAC - 16);
        return 64'(r_accel) >> (16 - SPD_FRAC);
    endfunction

    function automatic bit [15:0] speed_up();
        bit [63:0] fast;
        bit [63:0] sum;
        bit [15:0] per;
        fast = speed_limit(r_fast);
        sum  = 64'(speed) + accel_units();
        if (sum > SPEED_TOP || sum > fast) begin
            if (held_ticks < HOLD_MAX) held_ticks = held_ticks + 16'd1;
            sum = fast;
        end
        speed = SPD_W'(sum);
        per = period_of(64'(speed));
        if (per > r_fixed) return r_fixed;
        return per;
    endfunction

    function automatic bit [15:0] slow_down();
        bit [63:0] slow;
        bit [63:0] a;
        bit [63:0] s;
        slow = speed_limit(r_slow);
        a    = accel_units();
        if (held_ticks > 16'd0) begin
            held_ticks = held_ticks - 16'd1;
        end else begin
            s = 64'(speed);
            s = (s >= a) ? s - a : 64'd0;
            if (s < slow) s = slow;
            speed = SPD_W'(s);
        end
        return period_of(64'(speed));
    endfunction

    function automatic t_out_item next_axis_result(input t_in_item it);
        t_out_item r;
        longint    d;
        bit        accel_side;
        r = '0;
        if (it.mode == MODE_PRESET) begin
            axis_pos = it.preset_position;
            rec_tgt  = it.preset_position;
            r.at_target = (!pin_up && axis_pos == it.target_position);
        end else begin
            if (r_ramp) begin
                if (it.target_position != rec_tgt) begin
                    d = longint'(it.target_position) - longint'(rec_tgt);
                    mid_pos    = longint'(rec_tgt) + d / 2;
                    prev_tgt   = rec_tgt;
                    rec_tgt    = it.target_position;
                    speed      = SPD_W'(speed_limit(r_slow));
                    held_ticks = 16'd0;
                end
                if (prev_tgt != it.target_position) begin
                    // heading up accelerates below the midpoint, heading down above it
                    if (prev_tgt < it.target_position)
                        accel_side = longint'(axis_pos) < mid_pos;
                    else
                        accel_side = longint'(axis_pos) > mid_pos;
                    r.period = accel_side ? speed_up() : slow_down();
                    r.period_write = 1'b1;
                end
            end else begin
                r.period = r_fixed;
                r.period_write = 1'b1;
            end

            if (pin_up) begin
                pin_up = 1'b0;
            end else if (axis_pos < it.target_position) begin
                dir_down = 1'b0;
                axis_pos = axis_pos + 1'b1;
                pin_up   = 1'b1;
            end else if (axis_pos > it.target_position) begin
                dir_down = 1'b1;
                axis_pos = axis_pos - 1'b1;
                pin_up   = 1'b1;
            end else begin
                r.at_target = 1'b1;
            end
        end
        r.step_pulse = pin_up;
        r.direction  = dir_down;
        r.position   = axis_pos;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                axis_results_q.push_back(next_axis_result(in_data));
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                    gap_left = $urandom_range(0, 7);
                    in_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    in_data  <= cmd_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input bit [15:0] want,
                               input bit [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                results_seen++;
                if (axis_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, expected none actual %h",
                             $time, o_out_data);
                end else begin
                    want = axis_results_q.pop_front();
                    check_field("period", want.period, o_out_data.period);
                    check_field("period_write", want.period_write, o_out_data.period_write);
                    check_field("step_pulse", want.step_pulse, o_out_data.step_pulse);
                    check_field("direction", want.direction, o_out_data.direction);
                    check_field("position", want.position, o_out_data.position);
                    check_field("at_target", want.at_target, o_out_data.at_target);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL stepper_ramp_step_generator_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_cmd(input logic mode, input bit [15:0] tgt, input bit [15:0] pre);
        t_in_item it;
        it.mode            = mode;
        it.target_position = tgt;
        it.preset_position = pre;
        cmd_q.push_back(it);
        cmds_sent++;
    endtask

    function automatic bit [15:0] pick_pos();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [15:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_RAMP_ENABLE:  r_ramp  = val[0];
            CFG_FIXED_PERIOD: r_fixed = val;
            CFG_SLOW_PERIOD:  r_slow  = val;
            CFG_FAST_PERIOD:  r_fast  = val;
            CFG_ACCEL_STEP:   r_accel = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input bit ramp, input bit [15:0] fixed_per,
                            input bit [15:0] slow_per, input bit [15:0] fast_per,
                            input bit [15:0] accel);
        write_reg(CFG_RAMP_ENABLE, {15'd0, ramp});
        write_reg(CFG_FIXED_PERIOD, fixed_per);
        write_reg(CFG_SLOW_PERIOD, slow_per);
        write_reg(CFG_FAST_PERIOD, fast_per);
        write_reg(CFG_ACCEL_STEP, accel);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // every beat yields one result, so equal counts mean the block is idle
    task automatic wait_idle();
        do @(posedge i_clk); while (results_seen != cmds_sent);
    endtask

    // mostly complete moves near the current spot, some cut short, plus
    // presets and stray ticks anywhere in the range
    task automatic fill_moves(input int n);
        int        cnt;
        int        span;
        int        ticks;
        int        t;
        int        k;
        bit [15:0] pre;
        cnt = 0;
        while (cnt < n) begin
            k = $urandom_range(0, 9);
            if (k < 7) begin
                span = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 30);
                t = $urandom_range(0, 1) ? plan_pos + span : plan_pos - span;
                if (t < 0) t = 0;
                if (t > 65535) t = 65535;
                ticks = 2 * span + $urandom_range(1, 4);
                if ($urandom_range(0, 5) == 0) ticks = $urandom_range(1, ticks);
                repeat (ticks) add_cmd(MODE_TICK, 16'(t), 16'($urandom()));
                cnt += ticks;
                plan_pos = t;
            end else if (k < 8) begin
                pre = pick_pos();
                add_cmd(MODE_PRESET, $urandom_range(0, 1) ? pre : pick_pos(), pre);
                plan_pos = pre;
                cnt++;
            end else begin
                add_cmd(MODE_TICK, pick_pos(), 16'($urandom()));
                cnt++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults after reset; first tick has no motion pending
        add_cmd(MODE_TICK, 16'h0000, 16'h0000);
        add_cmd(MODE_PRESET, 16'hFFFF, 16'hFFFF);
        add_cmd(MODE_TICK, 16'hFFFF, 16'h0000);
        repeat (6) add_cmd(MODE_TICK, 16'hFFFD, 16'hFFFF);
        add_cmd(MODE_PRESET, 16'h0005, 16'h0000);
        add_cmd(MODE_TICK, 16'h0003, 16'h5555);
        // preset while the pin is still high
        add_cmd(MODE_PRESET, 16'h0001, 16'h0001);
        add_cmd(MODE_TICK, 16'h0001, 16'hAAAA);
        add_cmd(MODE_TICK, 16'h0001, 16'h0000);
        repeat (5) add_cmd(MODE_TICK, 16'h0003, 16'h0000);
        add_cmd(MODE_PRESET, 16'h7FFF, 16'h8000);
        repeat (3) add_cmd(MODE_TICK, 16'h7FFF, 16'h0000);
        add_cmd(MODE_PRESET, 16'h5555, 16'hAAAA);
        repeat (2) add_cmd(MODE_TICK, 16'h5555, 16'hFFFF);
        plan_pos = 16'hAAAA;
        fill_moves(40);
        wait_idle();

        for (int ph = 1; ph <= 9; ph++) begin
            case (ph)
                1: set_regs(1'b0, 16'h0000, 16'd1299, 16'd48, 16'd6554);
                2: set_regs(1'b0, 16'hFFFF, 16'd1299, 16'd48, 16'd6554);
                // fast limit reached well before the midpoint: long holds
                3: set_regs(1'b1, 16'hFFFF, 16'd2000, 16'd400, 16'hFFFF);
                // fast limit at the speed maximum: sums overflow
                4: set_regs(1'b1, 16'hFFFF, 16'd40, 16'd1, 16'hFFFF);
                // slow limit below one acceleration step: differences underflow
                5: set_regs(1'b1, 16'd1000, 16'hFFFF, 16'h0000, 16'hFFFF);
                6: set_regs(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                7: set_regs(1'b1, 16'd300, 16'd1, 16'hFFFF, 16'd1);
                default: set_regs($urandom_range(0, 3) != 0, 16'($urandom()),
                                  16'($urandom_range(500, 3000)),
                                  16'($urandom_range(20, 500)), 16'($urandom()));
            endcase
            idle_pct = (ph == 9) ? 0 : ((ph % 2) ? 30 : 12);
            fill_moves((ph == 3 || ph >= 8) ? 90 : 60);
            wait_idle();
        end

        repeat (150) @(posedge i_clk);
        if (mismatches == 0 && axis_results_q.size() == 0) begin
            $display("PASS stepper_ramp_step_generator_top");
        end else begin
            $display("FAIL stepper_ramp_step_generator_top");
        end
        $finish;
    end

endmodule
